// ===== rtl/hgept_pkg.sv =====
// Shared types and constants for the hysteresis gate edge and period tracker.
// Used by hgept_core and hysteresis_gate_edge_period_tracker; depends on nothing.
`default_nettype none

package hgept_pkg;

    localparam int ADC_BITS      = 12;
    localparam int FRAME_BITS    = 32;
    localparam int CONF_BITS     = 7;
    localparam int GLITCH_BITS   = 32;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 12;

    localparam logic [ADC_BITS-1:0]  ZERO_OFFSET_RST = ADC_BITS'(0);
    localparam logic [ADC_BITS-1:0]  ON_THRESH_RST   = ADC_BITS'(2048);
    localparam logic [ADC_BITS-1:0]  OFF_THRESH_RST  = ADC_BITS'(1024);
    localparam logic [CONF_BITS-1:0] CONFIRM_RST     = CONF_BITS'(3);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_ZERO_OFFSET    = 3'd0,
        CFG_ZERO_VALID     = 3'd1,
        CFG_ON_THRESHOLD   = 3'd2,
        CFG_OFF_THRESHOLD  = 3'd3,
        CFG_CONFIRM_FRAMES = 3'd4
    } cfg_index_t;

    typedef enum logic [1:0] {
        EDGE_NONE = 2'd0,
        EDGE_RISE = 2'd1,
        EDGE_FALL = 2'd2
    } edge_kind_t;

    typedef struct packed {
        logic [ADC_BITS-1:0]  zero_offset;
        logic                 zero_valid;
        logic [ADC_BITS-1:0]  on_threshold;
        logic [ADC_BITS-1:0]  off_threshold;
        logic [CONF_BITS-1:0] confirm_frames;
    } cfg_t;

    typedef struct packed {
        logic [ADC_BITS-1:0] raw_sample;
        logic                restart;
    } in_req_t;

    typedef struct packed {
        logic                   gate_on;
        edge_kind_t             edge_kind;
        logic [FRAME_BITS-1:0]  edge_frame;
        logic                   period_found;
        logic                   period_new;
        logic [FRAME_BITS-1:0]  latch_frame;
        logic [FRAME_BITS-1:0]  rise_frame;
        logic [FRAME_BITS-1:0]  fall_frame;
        logic [GLITCH_BITS-1:0] glitch_count;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/hgept_core.sv =====
// Tracking state and per-sample logic: offset, hysteresis, debounce, edges, period capture.
// Depends on hgept_pkg.
`default_nettype none

module hgept_core (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire hgept_pkg::cfg_t  cfg,
    input  wire logic             step,
    input  wire hgept_pkg::in_req_t req,
    output hgept_pkg::result_t    res
);

    localparam int AB = hgept_pkg::ADC_BITS;
    localparam int FB = hgept_pkg::FRAME_BITS;
    localparam int CB = hgept_pkg::CONF_BITS;
    localparam int GB = hgept_pkg::GLITCH_BITS;

    logic          started_reg,   started_next;
    logic          gate_reg,      gate_next;
    logic [CB-1:0] run_reg,       run_next;
    logic [GB-1:0] glitch_reg,    glitch_next;
    logic [FB-1:0] frame_reg,     frame_next;
    logic [FB-1:0] last_rise_reg, last_rise_next;
    logic [FB-1:0] last_fall_reg, last_fall_next;
    logic          rise_seen_reg, rise_seen_next;
    logic          fall_seen_reg, fall_seen_next;
    logic          captured_reg,  captured_next;
    logic [FB-1:0] cap_latch_reg, cap_latch_next;
    logic [FB-1:0] cap_rise_reg,  cap_rise_next;
    logic [FB-1:0] cap_fall_reg,  cap_fall_next;

    logic [AB-1:0] offset;
    logic [AB-1:0] level;
    logic [CB-1:0] confirm;
    logic [CB-1:0] confirm_m1;
    logic [CB-1:0] run_inc;
    logic          crossed;
    logic          fresh;
    logic [FB-1:0] edge_at;
    hgept_pkg::edge_kind_t kind;

    always_comb begin
        offset     = cfg.zero_valid ? cfg.zero_offset : '0;
        level      = (req.raw_sample > offset) ? (req.raw_sample - offset) : '0;
        confirm    = (cfg.confirm_frames == '0) ? CB'(1) : cfg.confirm_frames;
        confirm_m1 = confirm - CB'(1);

        // restart clears tracking before this sample is applied
        if (req.restart) begin
            started_next   = 1'b0;
            gate_next      = 1'b0;
            run_next       = '0;
            glitch_next    = '0;
            frame_next     = '0;
            last_rise_next = '0;
            last_fall_next = '0;
            rise_seen_next = 1'b0;
            fall_seen_next = 1'b0;
            captured_next  = 1'b0;
            cap_latch_next = '0;
            cap_rise_next  = '0;
            cap_fall_next  = '0;
        end else begin
            started_next   = started_reg;
            gate_next      = gate_reg;
            run_next       = run_reg;
            glitch_next    = glitch_reg;
            frame_next     = frame_reg;
            last_rise_next = last_rise_reg;
            last_fall_next = last_fall_reg;
            rise_seen_next = rise_seen_reg;
            fall_seen_next = fall_seen_reg;
            captured_next  = captured_reg;
            cap_latch_next = cap_latch_reg;
            cap_rise_next  = cap_rise_reg;
            cap_fall_next  = cap_fall_reg;
        end

        crossed = gate_next ? (level <= cfg.off_threshold) : (level >= cfg.on_threshold);
        run_inc = crossed ? CB'(run_next + CB'(1)) : '0;
        edge_at = frame_next - FB'(confirm_m1);
        kind    = hgept_pkg::EDGE_NONE;
        fresh   = 1'b0;

        if (!started_next) begin
            gate_next    = level >= cfg.on_threshold;
            started_next = 1'b1;
        end else begin
            if (!crossed && run_next != '0) begin
                glitch_next = glitch_next + GB'(1);
            end
            run_next = run_inc;
            if (run_inc >= confirm) begin
                run_next  = '0;
                gate_next = !gate_next;
                if (gate_next) begin
                    kind           = hgept_pkg::EDGE_RISE;
                    last_rise_next = edge_at;
                    rise_seen_next = 1'b1;
                end else begin
                    kind = hgept_pkg::EDGE_FALL;
                    if (rise_seen_next && fall_seen_next) begin
                        captured_next  = 1'b1;
                        fresh          = 1'b1;
                        cap_rise_next  = last_rise_next;
                        cap_fall_next  = edge_at;
                        cap_latch_next = last_fall_next;
                    end
                    rise_seen_next = 1'b0;
                    last_fall_next = edge_at;
                    fall_seen_next = 1'b1;
                end
            end
        end

        frame_next = frame_next + FB'(1);

        res.gate_on      = gate_next;
        res.edge_kind    = kind;
        res.edge_frame   = (kind == hgept_pkg::EDGE_NONE) ? '0 : edge_at;
        res.period_found = captured_next;
        res.period_new   = fresh;
        res.latch_frame  = cap_latch_next;
        res.rise_frame   = cap_rise_next;
        res.fall_frame   = cap_fall_next;
        res.glitch_count = glitch_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            started_reg   <= 1'b0;
            gate_reg      <= 1'b0;
            run_reg       <= '0;
            glitch_reg    <= '0;
            frame_reg     <= '0;
            last_rise_reg <= '0;
            last_fall_reg <= '0;
            rise_seen_reg <= 1'b0;
            fall_seen_reg <= 1'b0;
            captured_reg  <= 1'b0;
            cap_latch_reg <= '0;
            cap_rise_reg  <= '0;
            cap_fall_reg  <= '0;
        end else if (step) begin
            started_reg   <= started_next;
            gate_reg      <= gate_next;
            run_reg       <= run_next;
            glitch_reg    <= glitch_next;
            frame_reg     <= frame_next;
            last_rise_reg <= last_rise_next;
            last_fall_reg <= last_fall_next;
            rise_seen_reg <= rise_seen_next;
            fall_seen_reg <= fall_seen_next;
            captured_reg  <= captured_next;
            cap_latch_reg <= cap_latch_next;
            cap_rise_reg  <= cap_rise_next;
            cap_fall_reg  <= cap_fall_next;
        end
    end

    edge_on_rise_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && res.edge_kind != hgept_pkg::EDGE_NONE) |-> (res.gate_on != gate_reg
            || req.restart))
        else $error("edge reported without a gate change");

    capture_needs_fall: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && fresh) |-> (rise_seen_reg && fall_seen_reg && !req.restart))
        else $error("period captured without rise and earlier fall");

    frame_advances: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && !req.restart) |=> (frame_reg == $past(frame_reg) + FB'(1)))
        else $error("frame counter did not advance");

endmodule

`default_nettype wire

// ===== rtl/hysteresis_gate_edge_period_tracker.sv =====
// Top level: configuration registers, request register, result register and handshakes.
// Depends on hgept_pkg and hgept_core.
//
//   channel  ports                          direction  carries
//   s_       s_valid, s_ready, s_req        in         in_req_t (raw_sample, restart)
//   m_       m_valid, m_ready, m_res        out        result_t (gate, edge, period, glitches)
//   cfg_     cfg_wr_en, cfg_index, cfg_wdata in        register writes, no read-back
//
// One request per cycle sustained while m_ready is high; a result is offered once it is in the result register.
// The request register feeds the tracking logic, whose result lands in the result register.
// With m_ready low both registers fill, so up to two requests are held before s_ready drops.
// Reset (aresetn low, synchronous) loads register defaults and clears all tracking.
`default_nettype none

module hysteresis_gate_edge_period_tracker (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    input  wire logic                                    s_valid,
    output logic                                         s_ready,
    input  wire hgept_pkg::in_req_t                      s_req,
    output logic                                         m_valid,
    input  wire logic                                    m_ready,
    output hgept_pkg::result_t                           m_res,
    input  wire logic                                    cfg_wr_en,
    input  wire logic [hgept_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  wire logic [hgept_pkg::CFG_DATA_BITS-1:0]     cfg_wdata
);

    localparam int AB = hgept_pkg::ADC_BITS;
    localparam int CB = hgept_pkg::CONF_BITS;

    hgept_pkg::cfg_t    cfg_reg;
    hgept_pkg::in_req_t req_reg;
    logic               req_valid_reg;
    hgept_pkg::result_t res_reg;
    logic               res_valid_reg;
    hgept_pkg::result_t core_res;
    logic               advance;

    assign advance = req_valid_reg && (!res_valid_reg || m_ready);
    assign s_ready = !req_valid_reg || advance;
    assign m_valid = res_valid_reg;
    assign m_res   = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.zero_offset    <= hgept_pkg::ZERO_OFFSET_RST;
            cfg_reg.zero_valid     <= 1'b0;
            cfg_reg.on_threshold   <= hgept_pkg::ON_THRESH_RST;
            cfg_reg.off_threshold  <= hgept_pkg::OFF_THRESH_RST;
            cfg_reg.confirm_frames <= hgept_pkg::CONFIRM_RST;
        end else if (cfg_wr_en) begin
            unique case (hgept_pkg::cfg_index_t'(cfg_index))
                hgept_pkg::CFG_ZERO_OFFSET:    cfg_reg.zero_offset    <= cfg_wdata[AB-1:0];
                hgept_pkg::CFG_ZERO_VALID:     cfg_reg.zero_valid     <= cfg_wdata[0];
                hgept_pkg::CFG_ON_THRESHOLD:   cfg_reg.on_threshold   <= cfg_wdata[AB-1:0];
                hgept_pkg::CFG_OFF_THRESHOLD:  cfg_reg.off_threshold  <= cfg_wdata[AB-1:0];
                hgept_pkg::CFG_CONFIRM_FRAMES: cfg_reg.confirm_frames <= cfg_wdata[CB-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                req_valid_reg <= 1'b1;
            end else if (advance) begin
                req_valid_reg <= 1'b0;
            end
            if (advance) begin
                res_valid_reg <= 1'b1;
            end else if (m_ready) begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg <= s_req;
        end
        if (advance) begin
            res_reg <= core_res;
        end
    end

    hgept_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .step    (advance),
        .req     (req_reg),
        .res     (core_res)
    );

    new_period_is_fall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_res.period_new) |->
            (m_res.edge_kind == hgept_pkg::EDGE_FALL && m_res.period_found))
        else $error("new period without a fall edge");

    no_edge_no_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_res.edge_kind == hgept_pkg::EDGE_NONE) |-> (m_res.edge_frame == '0))
        else $error("edge frame set without an edge");

    edge_matches_gate: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_res.edge_kind != hgept_pkg::EDGE_NONE) |->
            (m_res.gate_on == (m_res.edge_kind == hgept_pkg::EDGE_RISE)))
        else $error("edge kind disagrees with gate state");

    held_request_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        (req_valid_reg && !advance) |=> (req_valid_reg && $stable(req_reg)))
        else $error("held request lost while result stalled");

endmodule

`default_nettype wire
